### sv/cum_pkg.sv
package cum_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHERISH_0 = 3'd0,
		REG_CHERISH_1 = 3'd1,
		REG_CHERISH_2 = 3'd2,
		REG_CHERISH_3 = 3'd3,
		REG_ECN       = 3'd4,
		REG_MAX_URG   = 3'd5,
		REG_MAX_CHER  = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ACT_ACCEPTED = 2'd0,
		ACT_DROPPED  = 2'd1,
		ACT_SERVED   = 2'd2,
		ACT_NOTHING  = 2'd3
	} action_t;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_SERVE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       opcode;
		logic [1:0] source_queue;
		logic [7:0] urgency_level;
		logic [7:0] cherish_level;
		logic [15:0] random_value;
		logic       output_ready;
	} req_t;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] result_queue;
		logic       mark_congestion;
		logic       wake_scheduler;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture request, read urgency FIFO head
		logic fetch;  // read stamp FIFO head of that queue
		logic exec;   // decide and update state
	} cmd_t;

endpackage

### sv/cum_if.sv
interface cum_req_if;
	import cum_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cum_rsp_if;
	import cum_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cum_cfg_if;
	import cum_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### sv/cum_ctrl.sv
module cum_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cum_pkg::cmd_t cmd
);
	import cum_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_nx = ST_READ;
			ST_READ: state_nx = ST_EXEC;
			ST_EXEC: state_nx = ST_OUT;
			ST_OUT: begin
				if (out_ready) state_nx = in_valid ? ST_READ : ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_READ: cmd.fetch = 1'b1;
			ST_EXEC: cmd.exec = 1'b1;
			ST_OUT: begin
				out_valid = 1'b1;
				in_ready = out_ready;
			end
			default: ;
		endcase
		cmd.load = in_valid & in_ready;
	end

	a_read_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_READ) else $error("load not followed by read");
	a_out_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |=> out_valid) else $error("exec not followed by result");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule

### sv/cum_dp.sv
module cum_dp #(
	parameter int URGENCY_LEVELS = 4,
	parameter int CHERISH_LEVELS = 4,
	parameter int SOURCE_QUEUES  = 4,
	parameter int FIFO_DEPTH     = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  cum_pkg::cmd_t cmd,
	input  cum_pkg::req_t req,
	input  logic cfg_we,
	input  logic [cum_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cum_pkg::CFG_DATA_W-1:0] cfg_data,
	output cum_pkg::rsp_t rsp
);
	import cum_pkg::*;

	localparam int UW = (URGENCY_LEVELS > 1) ? $clog2(URGENCY_LEVELS) : 1;
	localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FW = $clog2(FIFO_DEPTH + 1);
	localparam int TW = $clog2(URGENCY_LEVELS * FIFO_DEPTH + 1);
	localparam int UAW = $clog2(URGENCY_LEVELS * FIFO_DEPTH);
	localparam int SAW = $clog2(SOURCE_QUEUES * FIFO_DEPTH);
	localparam logic [1:0] ULIM = (URGENCY_LEVELS - 1 > 3) ? 2'd3 : 2'(URGENCY_LEVELS - 1);
	localparam logic [1:0] CLIM = 2'(CHERISH_LEVELS - 1);

	// configuration
	logic [48:0] cher_q [4];
	logic [63:0] ecn_q;
	logic [1:0] max_urg_q, max_cher_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				cher_q[i] <= {17'h08000, 16'(32 - 8 * i), 16'(40 - 10 * i)};
			ecn_q <= 64'h0001000100010001;
			max_urg_q <= 2'd3;
			max_cher_q <= 2'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHERISH_0, REG_CHERISH_1, REG_CHERISH_2, REG_CHERISH_3:
					cher_q[cfg_index[1:0]] <= cfg_data[48:0];
				REG_ECN: ecn_q <= cfg_data;
				REG_MAX_URG: max_urg_q <= cfg_data[1:0];
				REG_MAX_CHER: max_cher_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// state
	logic [PW-1:0] uhead_q [URGENCY_LEVELS];
	logic [FW-1:0] ufill_q [URGENCY_LEVELS];
	logic [PW-1:0] shead_q [4];
	logic [FW-1:0] sfill_q [4];
	logic [TW-1:0] total_q;
	logic [15:0] seq_q;

	logic [1:0]  ustore [URGENCY_LEVELS * FIFO_DEPTH];
	logic [15:0] sstore [SOURCE_QUEUES * FIFO_DEPTH];

	// ring position head + offset; the sum wraps at most once
	function automatic logic [PW-1:0] wrap_pos(input logic [PW-1:0] head,
			input logic [FW-1:0] ofs);
		logic [FW:0] s;
		s = (FW+1)'(head) + (FW+1)'(ofs);
		if (s >= (FW+1)'(FIFO_DEPTH))
			s = s - (FW+1)'(FIFO_DEPTH);
		return PW'(s);
	endfunction

	// stage 1: request and effective limits
	req_t req_s1;
	logic [1:0] ulim, clim, ucl, ccl, src_pos;
	logic [UW-1:0] uidx, sel_u;
	logic sel_found;

	function automatic logic [1:0] clamp(input logic [7:0] v, input logic [1:0] lim);
		if (v[7]) return 2'd0;
		if (v > {6'd0, lim}) return lim;
		return v[1:0];
	endfunction

	always_comb begin
		ulim = (max_urg_q > ULIM) ? ULIM : max_urg_q;
		clim = (max_cher_q > CLIM) ? CLIM : max_cher_q;
		ucl = clamp(req_s1.urgency_level, ulim);
		ccl = clamp(req_s1.cherish_level, clim);
		uidx = UW'(ucl);
		src_pos = req_s1.source_queue;
		sel_found = 1'b0;
		sel_u = '0;
		for (int i = URGENCY_LEVELS - 1; i >= 0; i--) begin
			if (i <= 3 && 2'(i) <= ulim && ufill_q[i] != '0) begin
				sel_found = 1'b1;
				sel_u = UW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_s1 <= req;
	end

	// Head reads, registered: the urgency head is read while the request is
	// taken (state is settled then), the stamp head of that queue in the cycle after.
	logic [1:0]     uhd_q;
	logic [15:0]    shd_q;
	logic [UAW-1:0] urd_addr, uwr_addr;
	logic [SAW-1:0] srd_addr, swr_addr;

	logic [48:0] cfg;
	logic [15:0] hard, soft_th;
	logic [16:0] prob;
	logic drop, serve, is_add, sfull_rd;
	logic [15:0] stamp, age, th;
	rsp_t rsp_nx;

	assign is_add = (req_s1.opcode == OP_ADD);
	assign cfg = cher_q[ccl];
	assign hard = cfg[15:0];
	assign soft_th = cfg[31:16];
	assign prob = cfg[48:32];
	assign drop = (32'(req_s1.source_queue) >= SOURCE_QUEUES) ||
		({{(32-16){1'b0}}, hard} < 32'(total_q)) ||
		(({{(32-16){1'b0}}, soft_th} < 32'(total_q)) &&
			(prob < {1'b0, req_s1.random_value})) ||
		(32'(ufill_q[uidx]) >= FIFO_DEPTH) || (32'(sfill_q[src_pos]) >= FIFO_DEPTH);
	assign serve = !is_add && total_q != '0 && sel_found;

	assign urd_addr = UAW'(32'(sel_u) * FIFO_DEPTH + 32'(uhead_q[sel_u]));
	assign srd_addr = SAW'(32'(uhd_q) * FIFO_DEPTH + 32'(shead_q[uhd_q]));
	assign uwr_addr = UAW'(32'(uidx) * FIFO_DEPTH +
		32'(wrap_pos(uhead_q[uidx], ufill_q[uidx])));
	assign swr_addr = SAW'(32'(src_pos) * FIFO_DEPTH +
		32'(wrap_pos(shead_q[src_pos], sfill_q[src_pos])));

	always_ff @(posedge clk) begin
		if (cmd.load) uhd_q <= ustore[urd_addr];
		if (cmd.fetch) shd_q <= sstore[srd_addr];
		if (cmd.exec && is_add && !drop) begin
			ustore[uwr_addr] <= src_pos;
			sstore[swr_addr] <= seq_q;
		end
	end

	always_comb begin
		sfull_rd = 32'(uhd_q) < SOURCE_QUEUES && sfill_q[uhd_q] != '0;
		stamp = sfull_rd ? shd_q : 16'd0;
		age = 16'(seq_q + 16'd1 - stamp);
		th = ecn_q[16 * uhd_q +: 16];
		if (th == 16'd0) th = 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < URGENCY_LEVELS; i++) begin
				uhead_q[i] <= '0;
				ufill_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) begin
				shead_q[i] <= '0;
				sfill_q[i] <= '0;
			end
			total_q <= '0;
			seq_q <= '0;
		end else if (cmd.exec) begin
			if (is_add && !drop) begin
				ufill_q[uidx] <= ufill_q[uidx] + FW'(1);
				sfill_q[src_pos] <= sfill_q[src_pos] + FW'(1);
				total_q <= total_q + TW'(1);
			end else if (serve) begin
				uhead_q[sel_u] <= wrap_pos(uhead_q[sel_u], FW'(1));
				ufill_q[sel_u] <= ufill_q[sel_u] - FW'(1);
				total_q <= total_q - TW'(1);
				seq_q <= seq_q + 16'd1;
				if (sfull_rd) begin
					shead_q[uhd_q] <= wrap_pos(shead_q[uhd_q], FW'(1));
					sfill_q[uhd_q] <= sfill_q[uhd_q] - FW'(1);
				end
			end
		end
	end

	// result register
	always_comb begin
		rsp_nx = '0;
		if (is_add) begin
			rsp_nx.result_queue = src_pos;
			rsp_nx.action = drop ? ACT_DROPPED : ACT_ACCEPTED;
			rsp_nx.wake_scheduler = !drop && total_q == '0 && req_s1.output_ready;
		end else if (serve) begin
			rsp_nx.action = ACT_SERVED;
			rsp_nx.result_queue = uhd_q;
			rsp_nx.mark_congestion = age > th;
		end else begin
			rsp_nx.action = ACT_NOTHING;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) rsp <= rsp_nx;
	end

	a_seq_on_serve: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && serve |=> seq_q == $past(seq_q) + 16'd1) else $error("sequence");
	a_count_add: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && is_add && !drop |=> total_q == $past(total_q) + TW'(1)) else $error("count");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> $stable(total_q)) else $error("count moved while idle");

endmodule

### sv/cherish_urgency_mux_top.sv
// Channel   Dir  Payload
// req       in   opcode, source_queue, urgency_level, cherish_level, random_value, output_ready
// rsp       out  action, result_queue, mark_congestion, wake_scheduler
// cfg       in   index (register number), data (write value)
//
// A request is handled in order: the accepting cycle reads the head of the lowest
// nonempty urgency FIFO, the next reads the stamp head of that source queue, and the
// decision cycle updates pointers, count and sequence and loads the output register.
// The next request is taken in the cycle its result is taken, so a new request is not
// accepted before the last result is taken. Reset (arst_n low) empties all FIFOs and
// restores register defaults. Config is always ready; write it only idle.
module cherish_urgency_mux_top #(
	parameter int URGENCY_LEVELS = 4,
	parameter int CHERISH_LEVELS = 4,
	parameter int SOURCE_QUEUES  = 4,
	parameter int FIFO_DEPTH     = 64
) (
	input logic clk,
	input logic arst_n,
	cum_req_if.sink   req,
	cum_rsp_if.source rsp,
	cum_cfg_if.sink   cfg
);
	import cum_pkg::*;

	cmd_t cmd;

	assign cfg.ready = 1'b1;

	// sequencer: capture / stamp read / decide / present
	cum_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.cmd(cmd)
	);

	// FIFOs, thresholds, count and sequence
	cum_dp #(
		.URGENCY_LEVELS(URGENCY_LEVELS), .CHERISH_LEVELS(CHERISH_LEVELS),
		.SOURCE_QUEUES(SOURCE_QUEUES), .FIFO_DEPTH(FIFO_DEPTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .req(req.data),
		.cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
		.rsp(rsp.data)
	);

endmodule
